>>> src/decimal_digit_alu_assert.svh
// assertion macros for the decimal digit alu
`ifndef DECIMAL_DIGIT_ALU_ASSERT_SVH
`define DECIMAL_DIGIT_ALU_ASSERT_SVH

// implication checked on every clock, off during reset
`define DDA_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define DDA_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

>>> src/dda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dda_pkg;

  localparam int unsigned DigitsDefault = 16;
  localparam int unsigned MaxDigits = 16;
  localparam int unsigned DataW = 4 * MaxDigits;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic [DataW-1:0] remainder;
    logic             negative;
    logic             divide_by_zero;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_MUL,
    ST_DIV_SHIFT,
    ST_DIV_SUB,
    ST_DONE
  } state_e;

  // one decimal digit adder or subtractor with carry or borrow
  typedef struct packed {
    logic [3:0] dig;
    logic       cy;
  } dsum_t;

  function automatic dsum_t dig_add(logic [3:0] a, logic [3:0] b, logic ci, logic sub);
    logic [4:0] s;
    dsum_t r;
    if (sub) begin
      s = {1'b0, a} - {1'b0, b} - {4'd0, ci};
      r.cy  = s[4];
      r.dig = s[4] ? 4'(s + 5'd10) : s[3:0];
    end else begin
      s = {1'b0, a} + {1'b0, b} + {4'd0, ci};
      r.cy  = (s > 5'd9);
      r.dig = (s > 5'd9) ? 4'(s - 5'd10) : s[3:0];
    end
    return r;
  endfunction

  function automatic logic [3:0] sat_dig(logic [3:0] n);
    return (n > 4'd9) ? 4'd9 : n;
  endfunction

endpackage
`default_nettype wire

>>> src/decimal_digit_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// decimal digit alu: add, subtract, multiply, divide on packed bcd operands
// start with busy low transfers op, operand_a and operand_b (digit 0 in bits
// 3..0, nibbles above 9 read as 9, nibbles at or above DIGITS ignored).
// busy stays high while the item is worked and through the result cycle;
// the result is shown for exactly one cycle with done_o high, busy drops
// the cycle after, and a new transfer is taken from then on.
// all arithmetic runs through one serial bcd digit adder/subtractor; one
// pass covers every operand digit plus one extra digit. work per item:
//   add, or subtract with a >= b: one pass
//   subtract with b > a: a second pass computes b - a
//   multiply: per multiplier digit d, d passes adding the shifted
//     multiplicand; a zero digit is skipped in a single step
//   divide: per quotient digit q, a shift step brings down the next dividend
//     digit, then q+1 trial subtraction passes; a zero divisor skips to the result
// the receiver cannot stall: a result not taken in its cycle is lost.
// reset returns the sequencer to idle and drops busy and done.
module decimal_digit_alu #(
  parameter int unsigned DIGITS = dda_pkg::DigitsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output      logic          busy,
  input  wire dda_pkg::in_t  in_i,
  output      logic          done_o,
  output      dda_pkg::out_t out_o
);
  localparam int unsigned W  = 4 * DIGITS;
  localparam int unsigned CW = $clog2(DIGITS + 1);
  localparam int unsigned XW = 4 * (DIGITS + 1);

  dda_pkg::state_e state_q, state_d;
  logic [1:0]    op_q;
  logic [W-1:0]  a_q, b_q;       // operand a, operand b
  logic [XW-1:0] acc_q;          // accumulator / partial remainder (one extra digit)
  logic [W-1:0]  res_q;          // product, quotient or result
  logic [XW-1:0] work_q;         // serial shift copy of acc or operand a during a pass
  logic [XW-1:0] opnd_q;         // serial shift copy of addend
  logic [CW-1:0] cnt_q;          // digit in pass
  logic [CW-1:0] pos_q;          // multiplier or quotient digit position
  logic [3:0]    rep_q;          // repeats left / quotient digit
  logic          neg_q, dz_q, pass2_q, sub_q;

  dda_pkg::dsum_t sum;
  logic clr, en;

  dda_digit_unit u_unit (
    .clk_i, .rst_ni, .clr_i(clr), .en_i(en), .sub_i(sub_q),
    .a_dig_i(work_q[3:0]), .b_dig_i(opnd_q[3:0]), .sum_o(sum)
  );

  // saturate and mask input digits
  function automatic logic [W-1:0] clean(logic [dda_pkg::DataW-1:0] x);
    logic [W-1:0] r;
    for (int i = 0; i < DIGITS; i++) r[4*i +: 4] = dda_pkg::sat_dig(x[4*i +: 4]);
    return r;
  endfunction

  wire pass_end = (cnt_q == CW'(DIGITS));
  wire [XW-1:0] pass_res = {sum.dig, work_q[XW-1:4]};

  assign busy = (state_q != dda_pkg::ST_IDLE);
  assign en   = (state_q == dda_pkg::ST_ADD) || (state_q == dda_pkg::ST_MUL) ||
                (state_q == dda_pkg::ST_DIV_SUB);
  // carry starts clear for every pass, and stays clear on a skipped digit
  assign clr  = (state_q == dda_pkg::ST_IDLE) || (en && pass_end) ||
                (state_q == dda_pkg::ST_DIV_SHIFT) ||
                ((state_q == dda_pkg::ST_MUL) && (rep_q == 4'd0));

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dda_pkg::ST_IDLE: if (start) begin
        unique case (dda_pkg::op_e'(in_i.op))
          dda_pkg::OP_ADD, dda_pkg::OP_SUB: state_d = dda_pkg::ST_ADD;
          dda_pkg::OP_MUL: state_d = dda_pkg::ST_MUL;
          dda_pkg::OP_DIV: state_d = (clean(in_i.operand_b) == '0) ? dda_pkg::ST_DONE
                                                                  : dda_pkg::ST_DIV_SHIFT;
          default: state_d = dda_pkg::ST_DONE;
        endcase
      end
      dda_pkg::ST_ADD: if (pass_end) begin
        if (sub_q && !pass2_q && sum.cy) state_d = dda_pkg::ST_ADD;
        else state_d = dda_pkg::ST_DONE;
      end
      dda_pkg::ST_MUL: if (pos_q == CW'(DIGITS - 1) &&
                           (rep_q == 4'd0 || (pass_end && rep_q == 4'd1))) begin
        state_d = dda_pkg::ST_DONE;
      end
      dda_pkg::ST_DIV_SHIFT: state_d = dda_pkg::ST_DIV_SUB;
      dda_pkg::ST_DIV_SUB: if (pass_end && sum.cy) begin
        state_d = (pos_q == '0) ? dda_pkg::ST_DONE : dda_pkg::ST_DIV_SHIFT;
      end
      dda_pkg::ST_DONE: state_d = dda_pkg::ST_IDLE;
      default: state_d = dda_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= dda_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      dda_pkg::ST_IDLE: if (start) begin
        op_q    <= in_i.op;
        a_q     <= clean(in_i.operand_a);
        b_q     <= clean(in_i.operand_b);
        neg_q   <= 1'b0;
        pass2_q <= 1'b0;
        dz_q    <= (in_i.op == dda_pkg::OP_DIV) && (clean(in_i.operand_b) == '0);
        cnt_q   <= '0;
        res_q   <= '0;
        acc_q   <= '0;
        sub_q   <= (in_i.op == dda_pkg::OP_SUB) || (in_i.op == dda_pkg::OP_DIV);
        pos_q   <= (in_i.op == dda_pkg::OP_DIV) ? CW'(DIGITS - 1) : '0;
        rep_q   <= dda_pkg::sat_dig(in_i.operand_b[3:0]);
        if (in_i.op == dda_pkg::OP_MUL) begin
          work_q <= '0;
          opnd_q <= {4'd0, clean(in_i.operand_a)};
        end else if (in_i.op == dda_pkg::OP_DIV) begin
          work_q <= '0;
          opnd_q <= '0;
        end else begin
          work_q <= {4'd0, clean(in_i.operand_a)};
          opnd_q <= {4'd0, clean(in_i.operand_b)};
        end
      end
      dda_pkg::ST_ADD: begin
        if (pass_end) begin
          cnt_q <= '0;
          if (sub_q && !pass2_q && sum.cy) begin
            // negative: compute b - a in a second pass
            neg_q   <= 1'b1;
            pass2_q <= 1'b1;
            work_q  <= {4'd0, b_q};
            opnd_q  <= {4'd0, a_q};
          end else begin
            res_q <= pass_res[W-1:0];
          end
        end else begin
          work_q <= pass_res;
          opnd_q <= {4'd0, opnd_q[XW-1:4]};
          cnt_q  <= cnt_q + CW'(1);
        end
      end
      dda_pkg::ST_MUL: begin
        if (rep_q == 4'd0) begin
          // zero multiplier digit: step to the next position
          cnt_q <= '0;
          if (pos_q == CW'(DIGITS - 1)) begin
            res_q <= acc_q[W-1:0];
          end else begin
            pos_q  <= pos_q + CW'(1);
            rep_q  <= b_q[4*(pos_q + CW'(1)) +: 4];
            work_q <= acc_q;
            opnd_q <= {4'd0, a_q << (4 * (pos_q + CW'(1)))};
          end
        end else if (pass_end) begin
          // one addition of the shifted multiplicand done
          acc_q  <= pass_res;
          work_q <= pass_res;
          cnt_q  <= '0;
          if (rep_q != 4'd1) begin
            rep_q  <= rep_q - 4'd1;
            opnd_q <= {4'd0, a_q << (4 * pos_q)};
          end else if (pos_q == CW'(DIGITS - 1)) begin
            res_q <= pass_res[W-1:0];
          end else begin
            pos_q  <= pos_q + CW'(1);
            rep_q  <= b_q[4*(pos_q + CW'(1)) +: 4];
            opnd_q <= {4'd0, a_q << (4 * (pos_q + CW'(1)))};
          end
        end else begin
          work_q <= pass_res;
          opnd_q <= {4'd0, opnd_q[XW-1:4]};
          cnt_q  <= cnt_q + CW'(1);
        end
      end
      dda_pkg::ST_DIV_SHIFT: begin
        // bring down the next dividend digit
        acc_q  <= {acc_q[XW-5:0], a_q[4*pos_q +: 4]};
        work_q <= {acc_q[XW-5:0], a_q[4*pos_q +: 4]};
        opnd_q <= {4'd0, b_q};
        rep_q  <= '0;
        cnt_q  <= '0;
      end
      dda_pkg::ST_DIV_SUB: begin
        if (pass_end) begin
          cnt_q <= '0;
          if (sum.cy) begin
            // borrow: trial failed, digit settled
            res_q <= {res_q[W-5:0], rep_q};
            if (pos_q != '0) pos_q <= pos_q - CW'(1);
          end else begin
            acc_q  <= pass_res;
            work_q <= pass_res;
            opnd_q <= {4'd0, b_q};
            rep_q  <= rep_q + 4'd1;
          end
        end else begin
          work_q <= pass_res;
          opnd_q <= {4'd0, opnd_q[XW-1:4]};
          cnt_q  <= cnt_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // result strobe
  always_comb begin
    done_o = (state_q == dda_pkg::ST_DONE);
    out_o  = '0;
    out_o.value[W-1:0] = res_q;
    if (op_q == dda_pkg::OP_DIV && !dz_q) out_o.remainder[W-1:0] = acc_q[W-1:0];
    out_o.negative       = neg_q;
    out_o.divide_by_zero = dz_q;
    if (dz_q) out_o.value = '0;
  end
endmodule
`default_nettype wire

>>> src/dda_digit_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// serial bcd adder/subtractor: one digit pair per cycle while en_i is high, with carry chain
module dda_digit_unit (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    clr_i,
  input  wire logic                    en_i,
  input  wire logic                    sub_i,
  input  wire logic [3:0]              a_dig_i,
  input  wire logic [3:0]              b_dig_i,
  output      dda_pkg::dsum_t          sum_o
);
  logic cy_q, cy_d;

  // digit add with carry held between cycles
  always_comb begin
    sum_o = dda_pkg::dig_add(a_dig_i, b_dig_i, cy_q, sub_i);
    cy_d  = clr_i ? 1'b0 : (en_i ? sum_o.cy : cy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cy_q <= 1'b0;
    end else begin
      cy_q <= cy_d;
    end
  end
endmodule
`default_nettype wire

>>> src/decimal_digit_alu_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "decimal_digit_alu_assert.svh"
// port-level checks
module decimal_digit_alu_chk (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done_o,
  input wire dda_pkg::out_t out_o
);
  `DDA_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  `DDA_ASSERT_IMP(a_done_busy, clk_i, rst_ni, done_o, busy)
  `DDA_ASSERT_NXT(a_done_once, clk_i, rst_ni, done_o, !done_o)
  `DDA_ASSERT_IMP(a_dz_zero, clk_i, rst_ni, done_o && out_o.divide_by_zero, out_o.value == '0)
endmodule

bind decimal_digit_alu decimal_digit_alu_chk u_chk (
  .clk_i, .rst_ni, .start, .busy, .done_o, .out_o
);
`default_nettype wire

>>> test/dda_checker.sv
`timescale 1ns / 1ps
module dda_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  dda_pkg::in_t  in_i,
  input  logic          done_o,
  input  dda_pkg::out_t out_o,
  output int            fail_count,
  output int            pending
);
  import dda_pkg::*;

  localparam int unsigned NDIG = DigitsDefault;

  out_t pending_results[$];

  // packed bcd to binary, nibbles saturated at 9, upper digits ignored
  function automatic logic [63:0] bcd_to_int(logic [DataW-1:0] x);
    logic [63:0] v;
    logic [3:0] nib;
    v = 0;
    for (int i = NDIG - 1; i >= 0; i--) begin
      nib = x[4*i +: 4];
      if (nib > 4'd9) nib = 4'd9;
      v = v * 10 + nib;
    end
    return v;
  endfunction

  function automatic logic [DataW-1:0] int_to_bcd(logic [63:0] v);
    logic [DataW-1:0] r;
    r = '0;
    for (int i = 0; i < NDIG; i++) begin
      r[4*i +: 4] = 4'(v % 10);
      v = v / 10;
    end
    return r;
  endfunction

  function automatic out_t alu_result(in_t item);
    out_t r;
    logic [63:0] a, b, m;
    logic [127:0] prod;
    r = '0;
    a = bcd_to_int(item.operand_a);
    b = bcd_to_int(item.operand_b);
    m = 1;
    for (int i = 0; i < NDIG; i++) m = m * 10;
    case (op_e'(item.op))
      OP_ADD: r.value = int_to_bcd((a + b) % m);
      OP_SUB: begin
        if (b > a) begin
          r.negative = 1'b1;
          r.value = int_to_bcd(b - a);
        end else begin
          r.value = int_to_bcd(a - b);
        end
      end
      // product below 10^32 fits 128 bits
      OP_MUL: begin
        prod = {64'd0, a} * {64'd0, b};
        r.value = int_to_bcd(64'(prod % {64'd0, m}));
      end
      default: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          r.value = int_to_bcd(a / b);
          r.remainder = int_to_bcd(a % b);
        end
      end
    endcase
    return r;
  endfunction

  assign pending = pending_results.size();

  // predict on each input transfer, compare on each result transfer
  always @(posedge clk_i) begin
    out_t want;
    if (!rst_ni) begin
      fail_count <= 0;
    end else begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", out_o);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_results.pop_front();
          if (out_o.value !== want.value || out_o.remainder !== want.remainder ||
              out_o.negative !== want.negative ||
              out_o.divide_by_zero !== want.divide_by_zero) begin
            if (fail_count < 10) $display("mismatch: expected %p got %p", want, out_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) pending_results.push_back(alu_result(in_i));
    end
  end
endmodule

>>> test/tb_decimal_digit_alu.sv
`timescale 1ns / 1ps
module tb_decimal_digit_alu;
  import dda_pkg::*;

  localparam longint CycleLimit = 64'd30_000_000;

  logic clk_i, rst_ni, start, busy, done_o;
  in_t in_i;
  out_t out_o;
  int fail_count, pending;
  longint cycles;

  decimal_digit_alu uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .in_i(in_i), .done_o(done_o), .out_o(out_o)
  );

  dda_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .in_i(in_i),
    .done_o(done_o), .out_o(out_o), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // timeout guard
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("[decimal_digit_alu] ERROR");
        $finish;
      end
    end
  end

  // random operand, mostly valid bcd, sometimes raw bits or few digits
  function automatic logic [DataW-1:0] rand_operand();
    logic [DataW-1:0] v;
    int unsigned len;
    v = '0;
    case ($urandom_range(0, 9))
      0: v = {$urandom, $urandom};
      1: v = '0;
      2: for (int i = 0; i < 16; i++) v[4*i +: 4] = 4'd9;
      default: begin
        len = $urandom_range(1, 16);
        for (int i = 0; i < len; i++) v[4*i +: 4] = 4'($urandom_range(0, 9));
      end
    endcase
    return v;
  endfunction

  // one transfer: drive at falling edge, hold until accepted
  task automatic send_item(logic [1:0] op, logic [DataW-1:0] a, logic [DataW-1:0] b);
    @(negedge clk_i);
    start <= 1'b1;
    in_i <= '{op: op, operand_a: a, operand_b: b};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  initial begin
    logic [DataW-1:0] nines, ones;
    int burst;
    start = 1'b0;
    in_i = '0;
    rst_ni = 1'b0;
    nines = {16{4'd9}};
    ones = {16{4'hF}};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed corners
    for (int o = 0; o < 4; o++) begin
      send_item(2'(o), '0, '0);
      send_item(2'(o), nines, nines);
      send_item(2'(o), ones, 64'h1);
      send_item(2'(o), 64'h12345, 64'h12345);
      send_item(2'(o), 64'h7, 64'h1234);
    end
    send_item(OP_ADD, nines, 64'h1);
    send_item(OP_DIV, nines, 64'h7);
    send_item(OP_MUL, 64'hAB00_0000_0000_0000, 64'h10);

    // drain before random part
    while (pending != 0) @(posedge clk_i);

    // random bursts, operands drawn from rand_operand
    for (int n = 0; n < 1900; ) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && n < 1900; k++, n++)
        send_item(2'($urandom_range(0, 3)), rand_operand(), rand_operand());
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 30)) @(negedge clk_i);
      if (n > 900 && n < 920) while (pending != 0) @(posedge clk_i);
    end

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[decimal_digit_alu] OK");
    end else begin
      $display("[decimal_digit_alu] ERROR");
    end
    $finish;
  end
endmodule
